>>> sv/counting_semaphore_table_core_defines.svh
// Assertion macros for the counting semaphore table core.
// Used by the RTL files that carry concurrent checks; depends on aclk and aresetn.
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_DEFINES_SVH

// Condition implies property in the same cycle.
`define CST_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("check failed");

// Condition implies property in the next cycle.
`define CST_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("check failed");

`endif

>>> sv/cst_pkg.sv
// Shared types, constants and index helpers for the counting semaphore table.
// No dependencies; used by counting_semaphore_table_core.
`timescale 1ns / 1ps
package cst_pkg;

    localparam int NUM_SEMAPHORES = 16;
    localparam int QUEUE_DEPTH    = 16;

    localparam int SLOT_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
    localparam int QP_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLEN_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int QMEM_DEPTH = NUM_SEMAPHORES * QUEUE_DEPTH;
    localparam int QADDR_W = (QMEM_DEPTH > 1) ? $clog2(QMEM_DEPTH) : 1;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_WAIT  = 2'd1,
        CMD_POST  = 2'd2,
        CMD_CLOSE = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_QUEUE_FULL = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_QSCAN,
        S_QREAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] name_key;
        logic [15:0] init_value;
        logic [7:0]  caller_pid;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic       caller_blocked;
        logic       woken_valid;
        logic [7:0] woken_pid;
    } out_t;

    // Reduce a pointer sum below twice the depth into the ring.
    function automatic logic [QP_W-1:0] qwrap(input logic [QLEN_W:0] v);
        logic [QLEN_W:0] r;
        r = v;
        if (v >= (QLEN_W+1)'(QUEUE_DEPTH)) begin
            r = v - (QLEN_W+1)'(QUEUE_DEPTH);
        end
        return r[QP_W-1:0];
    endfunction

    function automatic logic [QADDR_W-1:0] qaddr(input logic [SLOT_W-1:0] slot,
                                                 input logic [QP_W-1:0] ptr);
        return QADDR_W'(slot) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(ptr);
    endfunction

endpackage

>>> sv/cst_queue_ram.sv
// Simple dual-port RAM holding the wait queues of all slots.
// Generic; one write port, one registered read port.
`timescale 1ns / 1ps
module cst_queue_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/counting_semaphore_table_core.sv
// Counting semaphore table: key lookup sequencer, slot state and queue RAM.
// Depends on cst_pkg, cst_queue_ram and counting_semaphore_table_core_defines.svh.
`timescale 1ns / 1ps
`include "counting_semaphore_table_core_defines.svh"
// Usage:
//   s_valid/s_ready/s_data carry one command item (open, wait, post, close)
//   with its 64-bit name key, initial count and caller pid. m_valid/m_ready/
//   m_data return exactly one result item per command.
//   s_ready is high only while the sequencer is idle; one item is in work
//   at a time.
//   Flow: an accepted item's key search walks the slot table one entry per
//   cycle through a single 64-bit comparator and stops at the first match
//   (every slot on a miss); then the item is executed and handed off. A wait
//   that finds the count at zero with a non-empty queue walks the queue RAM
//   one entry per cycle, up to QUEUE_DEPTH entries; a post with waiters adds
//   a queue RAM read (S_QREAD) before the hand-off.
//   Reset (aresetn low, synchronous) frees every slot and empties every queue
//   at once; no clearing pass is needed.
//   If the receiver stalls, the result waits in the output register and the
//   sequencer holds its finished result until the register frees.
module counting_semaphore_table_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cst_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cst_pkg::out_t  m_data
);
    localparam int N  = cst_pkg::NUM_SEMAPHORES;
    localparam int SW = cst_pkg::SLOT_W;
    localparam int PW = cst_pkg::QP_W;
    localparam int LW = cst_pkg::QLEN_W;
    localparam int AW = cst_pkg::QADDR_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(N - 1);

    // Slot table
    logic          used_reg  [N];
    logic [63:0]   key_reg   [N];
    logic [15:0]   count_reg [N];
    logic [7:0]    opens_reg [N];
    logic [LW-1:0] qlen_reg  [N];
    logic [PW-1:0] head_reg  [N];

    // Sequencer
    cst_pkg::state_t state_reg, state_next;
    cst_pkg::in_t    req_reg, req_next;
    cst_pkg::out_t   res_reg, res_next;
    logic [SW-1:0]   idx_reg, idx_next;
    logic            hit_reg, hit_next;
    logic [SW-1:0]   hit_slot_reg, hit_slot_next;
    logic            free_ok_reg, free_ok_next;
    logic [SW-1:0]   free_slot_reg, free_slot_next;
    logic [LW-1:0]   qi_reg, qi_next;
    logic            m_valid_reg, m_valid_next;
    cst_pkg::out_t   m_data_reg, m_data_next;

    // Slot update strobes from the sequencer
    typedef struct packed {
        logic [SW-1:0] slot;
        logic          we_create;
        logic          we_free;
        logic          we_count;
        logic [15:0]   count;
        logic          we_opens;
        logic [7:0]    opens;
        logic          we_queue;
        logic [LW-1:0] qlen;
        logic [PW-1:0] head;
    } upd_t;
    upd_t upd;

    logic            q_we;
    logic [AW-1:0]   q_waddr;
    logic [AW-1:0]   q_raddr;
    logic [7:0]      q_rdata;
    logic [LW-1:0]   rd_i;

    logic [15:0]   cur_count;
    logic [7:0]    cur_opens;
    logic [LW-1:0] cur_qlen;
    logic [PW-1:0] cur_head;
    logic [PW-1:0] tail_ptr;

    assign cur_count = count_reg[hit_slot_reg];
    assign cur_opens = opens_reg[hit_slot_reg];
    assign cur_qlen  = qlen_reg[hit_slot_reg];
    assign cur_head  = head_reg[hit_slot_reg];
    assign tail_ptr  = cst_pkg::qwrap((LW+1)'(cur_head) + (LW+1)'(cur_qlen));
    assign q_raddr   = cst_pkg::qaddr(hit_slot_reg,
                           cst_pkg::qwrap((LW+1)'(cur_head) + (LW+1)'(rd_i)));
    assign q_waddr   = cst_pkg::qaddr(hit_slot_reg, tail_ptr);

    cst_queue_ram #(
        .DEPTH (cst_pkg::QMEM_DEPTH),
        .AW    (AW),
        .DW    (8)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (req_reg.caller_pid),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign s_ready = (state_reg == cst_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= cst_pkg::S_IDLE;
            m_valid_reg  <= 1'b0;
            hit_slot_reg <= '0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            hit_slot_reg <= hit_slot_next;
        end
        req_reg       <= req_next;
        res_reg       <= res_next;
        idx_reg       <= idx_next;
        hit_reg       <= hit_next;
        free_ok_reg   <= free_ok_next;
        free_slot_reg <= free_slot_next;
        qi_reg        <= qi_next;
        m_data_reg    <= m_data_next;
    end

    // Slot table writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) begin
                used_reg[i] <= 1'b0;
                qlen_reg[i] <= '0;
            end
        end else begin
            if (upd.we_create) begin
                used_reg[upd.slot] <= 1'b1;
                key_reg[upd.slot]  <= req_reg.name_key;
            end
            if (upd.we_free) begin
                used_reg[upd.slot] <= 1'b0;
            end
            if (upd.we_count) begin
                count_reg[upd.slot] <= upd.count;
            end
            if (upd.we_opens) begin
                opens_reg[upd.slot] <= upd.opens;
            end
            if (upd.we_queue) begin
                qlen_reg[upd.slot] <= upd.qlen;
                head_reg[upd.slot] <= upd.head;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        free_ok_next   = free_ok_reg;
        free_slot_next = free_slot_reg;
        qi_next        = qi_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        rd_i           = '0;
        q_we           = 1'b0;
        upd            = '0;
        upd.slot       = hit_slot_reg;
        upd.count      = cur_count;
        upd.opens      = cur_opens;
        upd.qlen       = cur_qlen;
        upd.head       = cur_head;

        // Drop the output item once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cst_pkg::S_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    idx_next     = '0;
                    hit_next     = 1'b0;
                    free_ok_next = 1'b0;
                    res_next     = '0;
                    state_next   = cst_pkg::S_SCAN;
                end
            end
            cst_pkg::S_SCAN: begin
                // One slot per cycle through the shared key comparator
                if (used_reg[idx_reg] && key_reg[idx_reg] == req_reg.name_key) begin
                    hit_next      = 1'b1;
                    hit_slot_next = idx_reg;
                    state_next    = cst_pkg::S_EXEC;
                end else begin
                    if (!used_reg[idx_reg] && !free_ok_reg) begin
                        free_ok_next   = 1'b1;
                        free_slot_next = idx_reg;
                    end
                    if (idx_reg == LAST_SLOT) begin
                        state_next = cst_pkg::S_EXEC;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            cst_pkg::S_EXEC: begin
                state_next = cst_pkg::S_DONE;
                if (req_reg.command == cst_pkg::CMD_OPEN) begin
                    if (hit_reg) begin
                        upd.we_opens = (cur_opens != 8'hFF);
                        upd.opens    = cur_opens + 8'd1;
                    end else if (free_ok_reg) begin
                        upd.slot      = free_slot_reg;
                        upd.we_create = 1'b1;
                        upd.we_count  = 1'b1;
                        upd.count     = req_reg.init_value;
                        upd.we_opens  = 1'b1;
                        upd.opens     = 8'd1;
                        upd.we_queue  = 1'b1;
                        upd.qlen      = '0;
                        upd.head      = '0;
                    end else begin
                        res_next.status = cst_pkg::ST_TABLE_FULL;
                    end
                end else if (!hit_reg) begin
                    res_next.status = cst_pkg::ST_NOT_FOUND;
                end else if (req_reg.command == cst_pkg::CMD_WAIT) begin
                    if (cur_count != 16'd0) begin
                        upd.we_count = 1'b1;
                        upd.count    = cur_count - 16'd1;
                    end else if (cur_qlen == '0) begin
                        // Empty queue: push without a search
                        q_we                    = 1'b1;
                        upd.we_queue            = 1'b1;
                        upd.qlen                = LW'(1);
                        res_next.caller_blocked = 1'b1;
                    end else begin
                        // Start the duplicate search at the head
                        rd_i       = '0;
                        qi_next    = '0;
                        state_next = cst_pkg::S_QSCAN;
                    end
                end else if (req_reg.command == cst_pkg::CMD_POST) begin
                    if (cur_qlen != '0) begin
                        rd_i       = '0;
                        state_next = cst_pkg::S_QREAD;
                    end else begin
                        upd.we_count = (cur_count != 16'hFFFF);
                        upd.count    = cur_count + 16'd1;
                    end
                end else begin
                    upd.we_opens = 1'b1;
                    upd.opens    = (cur_opens != 8'd0) ? cur_opens - 8'd1 : 8'd0;
                    if (cur_opens <= 8'd1) begin
                        upd.we_free  = 1'b1;
                        upd.we_queue = 1'b1;
                        upd.qlen     = '0;
                    end
                end
            end
            cst_pkg::S_QSCAN: begin
                // q_rdata holds entry qi_reg; fetch the next one meanwhile
                rd_i = qi_reg + 1'b1;
                if (q_rdata == req_reg.caller_pid) begin
                    res_next.caller_blocked = 1'b1;
                    state_next              = cst_pkg::S_DONE;
                end else if (qi_reg + 1'b1 == cur_qlen) begin
                    state_next = cst_pkg::S_DONE;
                    if (cur_qlen == LW'(cst_pkg::QUEUE_DEPTH)) begin
                        res_next.status = cst_pkg::ST_QUEUE_FULL;
                    end else begin
                        q_we                    = 1'b1;
                        upd.we_queue            = 1'b1;
                        upd.qlen                = cur_qlen + 1'b1;
                        res_next.caller_blocked = 1'b1;
                    end
                end else begin
                    qi_next = qi_reg + 1'b1;
                end
            end
            cst_pkg::S_QREAD: begin
                // Pop the oldest waiter
                res_next.woken_valid = 1'b1;
                res_next.woken_pid   = q_rdata;
                upd.we_queue         = 1'b1;
                upd.qlen             = cur_qlen - 1'b1;
                upd.head             = cst_pkg::qwrap((LW+1)'(cur_head) + (LW+1)'(1));
                state_next           = cst_pkg::S_DONE;
            end
            cst_pkg::S_DONE: begin
                // Hold the result until the output register frees
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = cst_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = cst_pkg::S_IDLE;
            end
        endcase
    end

    `CST_ASSERT_NXT(a_accept_starts_scan, s_valid && s_ready, state_reg == cst_pkg::S_SCAN)
    `CST_ASSERT_IMP(a_qlen_bound, 1'b1, qlen_reg[hit_slot_reg] <= LW'(cst_pkg::QUEUE_DEPTH))
    `CST_ASSERT_IMP(a_wake_is_ok, m_valid && m_data.woken_valid, m_data.status == cst_pkg::ST_OK)
    `CST_ASSERT_IMP(a_block_xor_wake, m_valid, !(m_data.caller_blocked && m_data.woken_valid))
endmodule
